/* rtl/rtcs_pkg.sv */
// Shared types, constants and field helpers for the serial RTC pin sequencer.
// No dependencies; imported by every module in rtl/.
package rtcs_pkg;

  localparam int unsigned NumFields = 7;
  localparam logic [15:0] HalfPeriodReset = 16'h0040;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  localparam logic [3:0] PIN_RD_OPEN   = 4'h1;
  localparam logic [3:0] PIN_RD_IDLE   = 4'h9;
  localparam logic [3:0] PIN_RD_CLK_LO = 4'hB;
  localparam logic [3:0] PIN_WR_OPEN   = 4'h5;
  localparam logic [3:0] PIN_WR_EN     = 4'hD;
  localparam logic [3:0] PIN_WR_LO     = 4'hC;
  localparam logic [3:0] PIN_WR_HI     = 4'hE;
  localparam logic [3:0] PIN_CLOSE     = 4'h1;

  localparam logic [2:0] CFG_HALF_PERIOD = 3'd0;

  typedef enum logic [8:0] {
    PH_IDLE    = 9'b000000001,
    PH_LEAD    = 9'b000000010,
    PH_OPEN_A  = 9'b000000100,
    PH_OPEN_B  = 9'b000001000,
    PH_BIT_LO  = 9'b000010000,
    PH_BIT_HI  = 9'b000100000,
    PH_TRAIL   = 9'b001000000,
    PH_CLOSE_A = 9'b010000000,
    PH_CLOSE_B = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       data_in;
    logic [7:0] wr_field0;
    logic [7:0] wr_field1;
    logic [7:0] wr_field2;
    logic [7:0] wr_field3;
    logic [7:0] wr_field4;
    logic [7:0] wr_field5;
    logic [7:0] wr_field6;
  } item_t;

  typedef struct packed {
    logic [3:0] pin_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_field0;
    logic [4:0] rd_field1;
    logic [5:0] rd_field2;
    logic [2:0] rd_field3;
    logic [5:0] rd_field4;
    logic [6:0] rd_field5;
    logic [6:0] rd_field6;
  } result_t;

  function automatic logic [7:0] field_mask(input logic [2:0] idx);
    logic [7:0] m;
    unique case (idx)
      3'd0:    m = 8'hFF;
      3'd1:    m = 8'h1F;
      3'd2:    m = 8'h3F;
      3'd3:    m = 8'h07;
      3'd4:    m = 8'h3F;
      3'd5:    m = 8'h7F;
      3'd6:    m = 8'h7F;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

  function automatic logic [3:0] field_bits(input logic [2:0] idx);
    return (idx == 3'd3) ? 4'd4 : 4'd8;
  endfunction

endpackage

/* rtl/rtcs_cfg.sv */
// APB-style register port holding the phase length register.
// Depends on rtcs_pkg.
module rtcs_cfg
  import rtcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] half_period
);

  logic [15:0] half_period_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == CFG_HALF_PERIOD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HalfPeriodReset;
    end else if (wr_en) begin
      half_period_r <= pwdata[15:0];
    end
  end

  assign prdata      = (paddr == CFG_HALF_PERIOD) ? {16'b0, half_period_r} : 32'b0;
  assign half_period = half_period_r;

endmodule

/* rtl/rtcs_core.sv */
// Sequencer state, field store and next-state logic for one item per cycle when adv is high.
// Depends on rtcs_pkg.
module rtcs_core
  import rtcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  item_t       item,
  input  logic [15:0] half_period,
  output result_t     res
);

  phase_t      phase_r, phase_nxt;
  logic        is_write_r, is_write_nxt;
  logic [2:0]  field_idx_r, field_idx_nxt;
  logic [3:0]  bit_idx_r, bit_idx_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [3:0]  pin_r, pin_nxt;
  logic [7:0]  store_r [NumFields];
  logic [7:0]  store_nxt [NumFields];
  logic        done;

  logic [15:0] period;
  logic [15:0] tick_inc;
  logic [3:0]  bit_inc;
  logic [7:0]  shift_dn;
  logic [7:0]  shift_rd;
  logic [2:0]  prev_idx;
  logic [7:0]  prev_word;

  assign period    = (half_period == 16'd0) ? 16'd1 : half_period;
  assign tick_inc  = tick_r + 16'd1;
  assign bit_inc   = bit_idx_r + 4'd1;
  assign shift_dn  = {1'b0, shift_r[7:1]};
  assign shift_rd  = shift_r | (8'(item.data_in) << bit_idx_r[2:0]);
  assign prev_idx  = field_idx_r - 3'd1;
  assign prev_word = store_r[prev_idx] & field_mask(prev_idx);

  always_comb begin
    phase_nxt     = phase_r;
    is_write_nxt  = is_write_r;
    field_idx_nxt = field_idx_r;
    bit_idx_nxt   = bit_idx_r;
    tick_nxt      = tick_r;
    shift_nxt     = shift_r;
    pin_nxt       = pin_r;
    store_nxt     = store_r;
    done          = 1'b0;

    unique case (item.req_type)
      REQ_TICK: begin
        if (phase_r != PH_IDLE) begin
          tick_nxt = tick_inc;
          if (tick_inc >= period) begin
            tick_nxt = 16'd0;
            unique case (phase_r)
              PH_LEAD: begin
                phase_nxt = PH_OPEN_A;
                pin_nxt   = is_write_r ? PIN_WR_OPEN : PIN_RD_OPEN;
              end
              PH_OPEN_A: begin
                phase_nxt = PH_OPEN_B;
                pin_nxt   = is_write_r ? PIN_WR_EN : PIN_RD_IDLE;
              end
              PH_OPEN_B: begin
                field_idx_nxt = 3'd6;
                bit_idx_nxt   = 4'd0;
                phase_nxt     = PH_BIT_LO;
                if (is_write_r) begin
                  shift_nxt = store_r[6] & field_mask(3'd6);
                  pin_nxt   = PIN_WR_LO | {3'b000, shift_nxt[0]};
                end else begin
                  shift_nxt = 8'd0;
                  pin_nxt   = PIN_RD_CLK_LO;
                end
              end
              PH_BIT_LO: begin
                phase_nxt = PH_BIT_HI;
                if (is_write_r) begin
                  pin_nxt = PIN_WR_HI | {3'b000, shift_r[0]};
                end else begin
                  shift_nxt = shift_rd;
                  pin_nxt   = PIN_RD_IDLE;
                end
              end
              PH_BIT_HI: begin
                bit_idx_nxt = bit_inc;
                if (is_write_r) begin
                  shift_nxt = shift_dn;
                  pin_nxt   = PIN_WR_LO | {3'b000, shift_dn[0]};
                  phase_nxt = (bit_inc >= field_bits(field_idx_r)) ? PH_TRAIL : PH_BIT_LO;
                end else if (bit_inc >= field_bits(field_idx_r)) begin
                  store_nxt[field_idx_r] = shift_r & field_mask(field_idx_r);
                  if (field_idx_r == 3'd0) begin
                    phase_nxt = PH_CLOSE_A;
                    pin_nxt   = PIN_RD_OPEN;
                  end else begin
                    field_idx_nxt = prev_idx;
                    bit_idx_nxt   = 4'd0;
                    shift_nxt     = 8'd0;
                    phase_nxt     = PH_BIT_LO;
                    pin_nxt       = PIN_RD_CLK_LO;
                  end
                end else begin
                  phase_nxt = PH_BIT_LO;
                  pin_nxt   = PIN_RD_CLK_LO;
                end
              end
              PH_TRAIL: begin
                if (field_idx_r == 3'd0) begin
                  phase_nxt = PH_CLOSE_A;
                  pin_nxt   = PIN_WR_OPEN;
                end else begin
                  field_idx_nxt = prev_idx;
                  bit_idx_nxt   = 4'd0;
                  shift_nxt     = prev_word;
                  phase_nxt     = PH_BIT_LO;
                  pin_nxt       = PIN_WR_LO | {3'b000, prev_word[0]};
                end
              end
              PH_CLOSE_A: begin
                phase_nxt = PH_CLOSE_B;
                pin_nxt   = PIN_CLOSE;
              end
              PH_CLOSE_B: begin
                phase_nxt = PH_IDLE;
                done      = 1'b1;
              end
              default: begin
                phase_nxt = PH_IDLE;
              end
            endcase
          end
        end
      end
      REQ_READ, REQ_WRITE: begin
        if (phase_r == PH_IDLE) begin
          is_write_nxt  = (item.req_type == REQ_WRITE);
          field_idx_nxt = 3'd0;
          bit_idx_nxt   = 4'd0;
          shift_nxt     = 8'd0;
          tick_nxt      = 16'd0;
          phase_nxt     = PH_LEAD;
          if (item.req_type == REQ_WRITE) begin
            store_nxt[0] = item.wr_field0 & field_mask(3'd0);
            store_nxt[1] = item.wr_field1 & field_mask(3'd1);
            store_nxt[2] = item.wr_field2 & field_mask(3'd2);
            store_nxt[3] = item.wr_field3 & field_mask(3'd3);
            store_nxt[4] = item.wr_field4 & field_mask(3'd4);
            store_nxt[5] = item.wr_field5 & field_mask(3'd5);
            store_nxt[6] = item.wr_field6 & field_mask(3'd6);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      is_write_r  <= 1'b0;
      field_idx_r <= 3'd0;
      bit_idx_r   <= 4'd0;
      tick_r      <= 16'd0;
      shift_r     <= 8'd0;
      pin_r       <= 4'd0;
    end else if (adv) begin
      phase_r     <= phase_nxt;
      is_write_r  <= is_write_nxt;
      field_idx_r <= field_idx_nxt;
      bit_idx_r   <= bit_idx_nxt;
      tick_r      <= tick_nxt;
      shift_r     <= shift_nxt;
      pin_r       <= pin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      store_r <= store_nxt;
    end
  end

  always_comb begin
    res.pin_drive = pin_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = done;
    res.rd_field0 = store_nxt[0];
    res.rd_field1 = store_nxt[1][4:0];
    res.rd_field2 = store_nxt[2][5:0];
    res.rd_field3 = store_nxt[3][2:0];
    res.rd_field4 = store_nxt[4][5:0];
    res.rd_field5 = store_nxt[5][6:0];
    res.rd_field6 = store_nxt[6][6:0];
  end

endmodule

/* rtl/serial_rtc_bitbang_sequencer.sv */
// Serial RTC pin sequencer: input register, sequencer core, result register.
// An accepted item waits in the input register; its result is registered when the
// core advances. Throughput: one item per cycle unless the output stalls; an empty
// input register takes a new item while a result waits on a stalled output.
// Synchronous active-low reset clears the sequencer to idle and the phase length to
// 64; the field store is not cleared. Depends on rtcs_pkg, rtcs_cfg and rtcs_core.
module serial_rtc_bitbang_sequencer
  import rtcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic        in_data_in,
  input  logic [7:0]  in_wr_field0,
  input  logic [7:0]  in_wr_field1,
  input  logic [7:0]  in_wr_field2,
  input  logic [7:0]  in_wr_field3,
  input  logic [7:0]  in_wr_field4,
  input  logic [7:0]  in_wr_field5,
  input  logic [7:0]  in_wr_field6,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_pin_drive,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [7:0]  out_rd_field0,
  output logic [4:0]  out_rd_field1,
  output logic [5:0]  out_rd_field2,
  output logic [2:0]  out_rd_field3,
  output logic [5:0]  out_rd_field4,
  output logic [6:0]  out_rd_field5,
  output logic [6:0]  out_rd_field6,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        in_v_r;
  item_t       item_r;
  logic        out_v_r;
  result_t     res_r;
  result_t     res;
  logic        adv;
  logic        in_take;
  logic [15:0] half_period;

  rtcs_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .half_period (half_period)
  );

  rtcs_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .item        (item_r),
    .half_period (half_period),
    .res         (res)
  );

  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && out_v_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (adv) begin
        in_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.req_type  <= in_req_type;
      item_r.data_in   <= in_data_in;
      item_r.wr_field0 <= in_wr_field0;
      item_r.wr_field1 <= in_wr_field1;
      item_r.wr_field2 <= in_wr_field2;
      item_r.wr_field3 <= in_wr_field3;
      item_r.wr_field4 <= in_wr_field4;
      item_r.wr_field5 <= in_wr_field5;
      item_r.wr_field6 <= in_wr_field6;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_v_r;
  assign out_pin_drive = res_r.pin_drive;
  assign out_busy_res  = res_r.busy_res;
  assign out_done_res  = res_r.done_res;
  assign out_rd_field0 = res_r.rd_field0;
  assign out_rd_field1 = res_r.rd_field1;
  assign out_rd_field2 = res_r.rd_field2;
  assign out_rd_field3 = res_r.rd_field3;
  assign out_rd_field4 = res_r.rd_field4;
  assign out_rd_field5 = res_r.rd_field5;
  assign out_rd_field6 = res_r.rd_field6;

endmodule
